// ===== src/ils_pkg.sv =====
// ils_pkg: shared types and constants for the integer literal scanner
// used by ils_classify and integer_literal_scanner_top, no dependencies

package ils_pkg;

   localparam int LEN_WIDTH     = 16;
   localparam int LEN_OUT_WIDTH = 16;
   localparam int VALUE_WIDTH   = 64;
   localparam int CHAR_WIDTH    = 8;
   localparam int LEN_CMP_WIDTH = (LEN_WIDTH > LEN_OUT_WIDTH) ? LEN_WIDTH : LEN_OUT_WIDTH;

   localparam logic [CHAR_WIDTH-1:0] SEP_CHAR = 8'h27;

   typedef enum logic [1:0] {
      RADIX_HEX = 2'd0,
      RADIX_DEC = 2'd1,
      RADIX_OCT = 2'd2,
      RADIX_BIN = 2'd3
   } radix_type;

   typedef enum logic [1:0] {
      KIND_TERM   = 2'd0,
      KIND_DIGIT  = 2'd1,
      KIND_REJECT = 2'd2,
      KIND_SEP    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
   } class_type;

endpackage

// ===== src/integer_literal_scanner_top.sv =====
// integer_literal_scanner_top: one character per item, radix literal scanner
// an accepted item is held in the input register, and its result is then written to the result register
// throughput: one item per cycle unless a held result stalls the input, set by the accumulator update
// reset: synchronous active-high reset clears the open literal and both valid stages
// depends on ils_pkg and ils_classify

module integer_literal_scanner_top
   import ils_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   input  logic [2:0]  req_tuser,   // start_req, radix_sel[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // value[63:0], length[15:0]
   output logic [0:0]  rsp_tuser    // status
);

   localparam logic [LEN_WIDTH-1:0]     CNT_MAX = {LEN_WIDTH{1'b1}};
   localparam logic [LEN_CMP_WIDTH-1:0] LEN_OUT_MAX =
      LEN_CMP_WIDTH'({LEN_OUT_WIDTH{1'b1}});

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [CHAR_WIDTH-1:0] in_ch_ff;
   logic                  in_start_ff;
   radix_type             in_radix_ff;

   // literal state
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [LEN_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   active_ff, active_in;
   radix_type              radix_ff, radix_in;

   // result register
   logic                     out_valid_ff, out_valid_in;
   logic                     out_status_ff, out_status_in;
   logic [VALUE_WIDTH-1:0]   out_value_ff, out_value_in;
   logic [LEN_OUT_WIDTH-1:0] out_len_ff, out_len_in;

   logic                   fire;
   logic                   emit;
   logic                   eff_active;
   radix_type              eff_radix;
   logic [VALUE_WIDTH-1:0] eff_acc;
   logic [LEN_WIDTH-1:0]   eff_cnt;
   logic [LEN_WIDTH-1:0]   cnt_inc;
   logic [VALUE_WIDTH-1:0] dig_ext;
   logic [LEN_CMP_WIDTH-1:0] cnt_wide;
   class_type              cls;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   assign eff_active = in_start_ff || active_ff;
   assign eff_radix  = in_start_ff ? in_radix_ff : radix_ff;
   assign eff_acc    = in_start_ff ? '0 : acc_ff;
   assign eff_cnt    = in_start_ff ? '0 : cnt_ff;

   ils_classify u_classify (
      .ch    (in_ch_ff),
      .radix (eff_radix),
      .cls   (cls)
   );

   always_comb begin
      dig_ext  = VALUE_WIDTH'(cls.digit);
      cnt_inc  = (eff_cnt == CNT_MAX) ? eff_cnt : eff_cnt + 1'b1;
      cnt_wide = LEN_CMP_WIDTH'(eff_cnt);
      emit     = fire && eff_active &&
                 ((cls.kind == KIND_TERM) || (cls.kind == KIND_REJECT));

      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      radix_in  = radix_ff;

      if (fire && eff_active) begin
         acc_in    = eff_acc;
         cnt_in    = eff_cnt;
         radix_in  = eff_radix;
         active_in = 1'b1;
         case (cls.kind)
            KIND_DIGIT: begin
               cnt_in = cnt_inc;
               case (eff_radix)
                  RADIX_HEX: acc_in = (eff_acc << 4) + dig_ext;
                  RADIX_DEC: acc_in = (eff_acc << 3) + (eff_acc << 1) + dig_ext;
                  RADIX_OCT: acc_in = (eff_acc << 3) + dig_ext;
                  RADIX_BIN: acc_in = (eff_acc << 1) + dig_ext;
                  default:   acc_in = eff_acc;
               endcase
            end
            KIND_SEP: begin
               cnt_in = cnt_inc;
            end
            default: begin
               active_in = 1'b0;
            end
         endcase
      end

      out_valid_in  = emit ? 1'b1 : (out_valid_ff && !rsp_tready);
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_len_in    = out_len_ff;
      if (emit) begin
         out_status_in = (cls.kind == KIND_REJECT);
         out_value_in  = (cls.kind == KIND_REJECT) ? '0 : eff_acc;
         out_len_in    = (cnt_wide > LEN_OUT_MAX) ? LEN_OUT_WIDTH'(LEN_OUT_MAX)
                                                  : LEN_OUT_WIDTH'(cnt_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         radix_ff     <= RADIX_HEX;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         active_ff    <= active_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         radix_ff     <= radix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_ch_ff    <= req_tdata;
         in_start_ff <= req_tuser[0];
         in_radix_ff <= radix_type'(req_tuser[2:1]);
      end
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_len_ff    <= out_len_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_len_ff, out_value_ff};
   assign rsp_tuser  = out_status_ff;

   // a rejected literal reports a zero value
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff) |-> (out_value_ff == '0))
      else $error("rejected item carries nonzero value");

   // a result always closes the open literal
   assert property (@(posedge clock) disable iff (reset)
      emit |=> !active_ff)
      else $error("literal still open after result");

   // a new result appears only after a processed item
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(fire))
      else $error("result without processed item");

   // the saturated count holds while the literal continues
   assert property (@(posedge clock) disable iff (reset)
      (fire && active_ff && !in_start_ff && (cnt_ff == CNT_MAX)) |=> (cnt_ff == CNT_MAX))
      else $error("character count left saturation");

endmodule

// ===== src/ils_classify.sv =====
// ils_classify: sorts one character into digit, separator, reject or terminator
// for the selected radix; depends on ils_pkg

module ils_classify
   import ils_pkg::*;
(
   input  logic [CHAR_WIDTH-1:0] ch,
   input  radix_type             radix,
   output class_type             cls
);

   logic is_dec;
   logic is_lower_hex;
   logic is_upper_hex;
   logic is_letter;
   logic is_oct;
   logic is_bin;

   always_comb begin
      is_dec       = (ch >= 8'h30) && (ch <= 8'h39);
      is_lower_hex = (ch >= 8'h61) && (ch <= 8'h66);
      is_upper_hex = (ch >= 8'h41) && (ch <= 8'h46);
      is_letter    = ((ch >= 8'h61) && (ch <= 8'h7a)) || ((ch >= 8'h41) && (ch <= 8'h5a));
      is_oct       = (ch >= 8'h30) && (ch <= 8'h37);
      is_bin       = (ch == 8'h30) || (ch == 8'h31);

      cls.digit = ch[3:0];
      cls.kind  = KIND_TERM;

      case (radix)
         RADIX_HEX: begin
            if (is_dec) begin
               cls.kind = KIND_DIGIT;
            end else if (is_lower_hex || is_upper_hex) begin
               cls.kind  = KIND_DIGIT;
               cls.digit = ch[3:0] + 4'd9;
            end else if (is_letter || (ch == 8'h5f)) begin
               cls.kind = KIND_REJECT;
            end
         end
         RADIX_DEC: begin
            if (is_dec) begin
               cls.kind = KIND_DIGIT;
            end else if (is_letter) begin
               cls.kind = KIND_REJECT;
            end
         end
         RADIX_OCT: begin
            if (is_oct) begin
               cls.kind = KIND_DIGIT;
            end else if (is_dec || is_letter) begin
               cls.kind = KIND_REJECT;
            end
         end
         RADIX_BIN: begin
            if (is_bin) begin
               cls.kind = KIND_DIGIT;
            end else if (is_dec || is_letter) begin
               cls.kind = KIND_REJECT;
            end
         end
         default: begin
            cls.kind = KIND_TERM;
         end
      endcase

      if ((cls.kind == KIND_TERM) && (ch == SEP_CHAR)) begin
         cls.kind = KIND_SEP;
      end
   end

endmodule

// ===== sim/integer_literal_scanner_top_test.sv =====
`timescale 1ns / 1ps
// integer_literal_scanner_top_test: self-checking bench for the literal scanner
// feeds character items with random gaps and back-pressure, predicts each literal
// result in the bench and checks it on the result stream; depends on ils_pkg

module integer_literal_scanner_top_test
   import ils_pkg::*;
();

   typedef struct packed {
      logic                     status;
      logic [VALUE_WIDTH-1:0]   value;
      logic [LEN_OUT_WIDTH-1:0] length;
   } literal_result_type;

   typedef struct {
      logic [7:0] ch;
      logic       start;
      radix_type  radix;
      int         gap;
   } char_item_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // ch
   logic [2:0]  req_tuser  = '0;   // start_req, radix_sel[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;         // value[63:0], length[15:0]
   logic [0:0]  rsp_tuser;         // status

   integer_literal_scanner_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // scanner state as the bench sees it
   logic [VALUE_WIDTH-1:0] scan_acc   = '0;
   logic [LEN_WIDTH-1:0]   scan_count = '0;
   logic                   scan_open  = 1'b0;
   radix_type              scan_radix = RADIX_HEX;

   char_item_type      char_queue[$];
   literal_result_type expected_literals[$];

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic rsp_hold = 1'b0;
   int   send_wait = 0;
   int   recv_wait = 0;
   int   items_sent = 0;
   int   results_seen = 0;
   int   rejects_seen = 0;
   int   mismatch_count = 0;
   int   literal_items = 0;

   initial forever #6 clock = ~clock;

   initial begin
      #1_500_000;
      $display("integer_literal_scanner_top verification failed");
      $finish;
   end

   function automatic kind_type sort_char(input logic [7:0] c, input radix_type r,
                                          output logic [3:0] d);
      logic       letter;
      logic       dec_digit;
      logic [7:0] off;
      letter    = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      dec_digit = (c >= "0" && c <= "9");
      d = c[3:0];
      case (r)
         RADIX_HEX: begin
            if (dec_digit) return KIND_DIGIT;
            if (c >= "a" && c <= "f") begin
               off = c - "a" + 8'd10;
               d = off[3:0];
               return KIND_DIGIT;
            end
            if (c >= "A" && c <= "F") begin
               off = c - "A" + 8'd10;
               d = off[3:0];
               return KIND_DIGIT;
            end
            if (letter || c == "_") return KIND_REJECT;
         end
         RADIX_DEC: begin
            if (dec_digit) return KIND_DIGIT;
            if (letter) return KIND_REJECT;
         end
         RADIX_OCT: begin
            if (c >= "0" && c <= "7") return KIND_DIGIT;
            if (c == "8" || c == "9" || letter) return KIND_REJECT;
         end
         default: begin
            if (c == "0" || c == "1") return KIND_DIGIT;
            if (dec_digit || letter) return KIND_REJECT;
         end
      endcase
      if (c == SEP_CHAR) return KIND_SEP;
      return KIND_TERM;
   endfunction

   function automatic void scan_char(input logic [7:0] c, input logic s, input radix_type r,
                                     output bit has_res, output literal_result_type res);
      kind_type   k;
      logic [3:0] d;
      has_res = 1'b0;
      res = '0;
      if (s) begin
         scan_open  = 1'b1;
         scan_radix = r;
         scan_acc   = '0;
         scan_count = '0;
      end
      if (!scan_open) return;
      k = sort_char(c, scan_radix, d);
      if (k == KIND_DIGIT || k == KIND_SEP) begin
         if (k == KIND_DIGIT) begin
            case (scan_radix)
               RADIX_HEX: scan_acc = (scan_acc << 4) + d;
               RADIX_DEC: scan_acc = scan_acc * 64'd10 + d;
               RADIX_OCT: scan_acc = (scan_acc << 3) + d;
               default:   scan_acc = (scan_acc << 1) + d;
            endcase
         end
         if (scan_count != '1) scan_count = scan_count + 1'b1;
      end else begin
         has_res    = 1'b1;
         res.status = (k == KIND_REJECT);
         res.value  = (k == KIND_REJECT) ? '0 : scan_acc;
         res.length = (scan_count > {LEN_OUT_WIDTH{1'b1}}) ? '1 : scan_count;
         scan_open  = 1'b0;
      end
   endfunction

   function automatic logic [7:0] pick_char(input radix_type r, input kind_type k);
      logic [7:0] c;
      logic [3:0] d;
      do c = 8'($urandom_range(0, 255)); while (sort_char(c, r, d) != k);
      return c;
   endfunction

   function automatic int draw_gap(input int idx);
      if ((idx / 80) % 4 == 1) return 0;
      return $urandom_range(0, 1) ? $urandom_range(0, 14) : 0;
   endfunction

   function automatic radix_type any_radix();
      return radix_type'(2'($urandom_range(0, 3)));
   endfunction

   task automatic push_char(input logic [7:0] c, input logic s, input radix_type r,
                            input int gap);
      char_item_type it;
      it.ch    = c;
      it.start = s;
      it.radix = r;
      it.gap   = gap;
      char_queue.push_back(it);
   endtask

   // sender
   always @(negedge clock) begin : sender
      char_item_type it;
      if (!reset && (!req_tvalid || req_fire)) begin
         if (char_queue.size() != 0 && send_wait != 0) begin
            send_wait--;
            req_tvalid <= 1'b0;
         end else if (char_queue.size() != 0) begin
            it = char_queue.pop_front();
            req_tdata  <= it.ch;
            req_tuser  <= {it.radix, it.start};
            req_tvalid <= 1'b1;
            send_wait = (char_queue.size() != 0) ? char_queue[0].gap : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin : receiver
      if (!reset) begin
         if (rsp_fire) begin
            if ((results_seen / 50) % 4 == 1) recv_wait = 0;
            else recv_wait = $urandom_range(0, 1) ? $urandom_range(0, 14) : 0;
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (recv_wait != 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the scanner backs up and stalls its input
   initial begin
      wait (results_seen >= 20);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin : monitor
      bit                 produced;
      literal_result_type want;
      literal_result_type got;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         rsp_fire <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            items_sent++;
            scan_char(req_tdata, req_tuser[0], radix_type'(req_tuser[2:1]), produced, want);
            if (produced) expected_literals.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], rsp_tdata[63:0], rsp_tdata[79:64]};
            results_seen++;
            if (got.status) rejects_seen++;
            if (expected_literals.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t unexpected result: status %0d value %h length %0d",
                           $realtime, got.status, got.value, got.length);
            end else begin
               want = expected_literals.pop_front();
               if (got.status !== want.status || got.value !== want.value ||
                   got.length !== want.length) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t mismatch: want %0d %h %0d, got %0d %h %0d",
                              $realtime, want.status, want.value, want.length,
                              got.status, got.value, got.length);
               end
            end
         end
      end
   end

   initial begin : stimulus
      radix_type r;
      int        n;
      int        k;
      bit        rejecting;
      logic [7:0] c;

      // directed literals
      push_char("x", 1'b0, RADIX_DEC, 0);
      push_char("f", 1'b1, RADIX_HEX, 0);
      push_char("F", 1'b0, RADIX_BIN, 0);
      push_char(SEP_CHAR, 1'b0, RADIX_HEX, 1);
      push_char("0", 1'b0, RADIX_HEX, 0);
      push_char("A", 1'b0, RADIX_HEX, 0);
      push_char(" ", 1'b0, RADIX_HEX, 2);
      push_char("g", 1'b1, RADIX_HEX, 0);
      push_char("1", 1'b1, RADIX_HEX, 0);
      push_char("_", 1'b0, RADIX_HEX, 0);
      push_char("9", 1'b1, RADIX_DEC, 0);
      push_char(SEP_CHAR, 1'b0, RADIX_DEC, 0);
      push_char("z", 1'b0, RADIX_DEC, 3);
      push_char(" ", 1'b1, RADIX_DEC, 0);
      push_char("7", 1'b1, RADIX_OCT, 0);
      push_char("8", 1'b0, RADIX_OCT, 0);
      push_char("1", 1'b1, RADIX_BIN, 0);
      push_char("0", 1'b0, RADIX_BIN, 0);
      push_char("2", 1'b0, RADIX_BIN, 0);
      push_char("1", 1'b1, RADIX_BIN, 0);
      push_char("7", 1'b1, RADIX_OCT, 0);
      push_char(8'hff, 1'b0, RADIX_OCT, 0);
      push_char("5", 1'b1, RADIX_DEC, 0);
      push_char(8'h80, 1'b0, RADIX_DEC, 0);
      push_char(SEP_CHAR, 1'b1, RADIX_HEX, 0);
      push_char(8'h00, 1'b0, RADIX_HEX, 0);
      push_char("Z", 1'b0, RADIX_BIN, 0);

      // random literals, mostly well formed, some abandoned, some noise between
      while (literal_items < 1000) begin
         r = any_radix();
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
         for (k = 0; k < n; k++) begin
            c = ($urandom_range(0, 5) == 0) ? SEP_CHAR : pick_char(r, KIND_DIGIT);
            push_char(c, k == 0, (k == 0) ? r : any_radix(), draw_gap(literal_items));
            literal_items++;
         end
         if (n == 0 || $urandom_range(0, 9) != 0) begin
            rejecting = ($urandom_range(0, 2) == 0);
            c = pick_char(r, rejecting ? KIND_REJECT : KIND_TERM);
            push_char(c, n == 0, (n == 0) ? r : any_radix(), draw_gap(literal_items));
            literal_items++;
         end
         if ($urandom_range(0, 5) == 0) begin
            for (k = $urandom_range(1, 3); k > 0; k--)
               push_char(8'($urandom_range(0, 255)), 1'b0, any_radix(),
                         draw_gap(literal_items));
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (char_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_literals.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d characters accepted, %0d literals checked (%0d rejected)",
               items_sent, results_seen, rejects_seen);
      $display("all four radixes, separators, abandoned starts, idle noise and stalls");
      if (mismatch_count == 0 && expected_literals.size() == 0) begin
         $display("integer_literal_scanner_top verification clean");
      end else begin
         $display("integer_literal_scanner_top verification failed");
      end
      $finish;
   end

endmodule
